@@ sv/wsd_pkg.sv @@
// Shared constants and controller/datapath interface types for window_std_deviation.
package wsd_pkg;

    localparam int SAMPLE_W   = 12;   // converter sample width
    localparam int WIN_W      = 13;   // window register and sample count width
    localparam int SUM_W      = 24;   // running sum
    localparam int SQ_W       = 36;   // running sum of squares
    localparam int MAX_WINDOW = 4096;
    localparam int WIN_RESET  = 100;
    localparam int STD_W      = 15;
    localparam int MEAN_W     = 16;

    // N*S2 is built from two partial products over the low and high halves of S2
    localparam int SPLIT_W = SQ_W / 2;
    localparam int PART_W  = WIN_W + SPLIT_W;
    localparam int NSQ_W   = WIN_W + SQ_W;
    localparam int PSQ_W   = 2 * SUM_W;

    // square root of 256*var, two radicand bits per step
    localparam int RAD_W  = 2 * ((NSQ_W + 8 + 1) / 2);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;

    // both divisions run over ROOT_W quotient bits
    localparam int STEPS  = ROOT_W;
    localparam int ITER_W = $clog2(STEPS);

    typedef struct packed {
        logic acc;        // sample transaction accepted
        logic mul_sq;     // S1*S1 and N*S2 low half
        logic mul_hi;     // N*S2 high half
        logic sum;        // combine partial products
        logic sub;        // variance, load root unit
        logic sqrt_step;  // one root digit
        logic div_load;   // load both divider lanes
        logic div_step;   // one quotient bit per lane
        logic out_load;   // capture result
    } t_cmd;

    typedef struct packed {
        logic close;      // current sample completes the window
    } t_status;

endpackage

@@ sv/wsd_ctrl.sv @@
// Sequencer for window_std_deviation: accumulate, multiply, root, divide, hand off.
module wsd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_sample_valid,
    output logic              o_sample_ready,
    output logic              o_result_valid,
    input  logic              i_result_ready,
    input  wsd_pkg::t_status  i_status,
    output wsd_pkg::t_cmd     o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MUL_SQ = 9'b000000010,
        S_MUL_HI = 9'b000000100,
        S_SUM    = 9'b000001000,
        S_SUB    = 9'b000010000,
        S_SQRT   = 9'b000100000,
        S_DIV_LD = 9'b001000000,
        S_DIVIDE = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    localparam logic [wsd_pkg::ITER_W-1:0] LAST_ITER = wsd_pkg::ITER_W'(wsd_pkg::STEPS - 1);

    t_state                     r_state, n_state;
    logic [wsd_pkg::ITER_W-1:0] r_iter, n_iter;
    logic                       r_out_valid, n_out_valid;
    logic                       accept;

    assign o_sample_ready = (r_state == S_IDLE);
    assign accept         = i_sample_valid & o_sample_ready;
    assign o_result_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_iter      = r_iter;
        n_out_valid = r_out_valid & ~i_result_ready;
        o_cmd       = '0;
        o_cmd.acc   = accept;
        case (r_state)
            S_IDLE: begin
                if (accept && i_status.close) begin
                    n_state = S_MUL_SQ;
                end
            end
            S_MUL_SQ: begin
                o_cmd.mul_sq = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_iter    = '0;
                n_state   = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_iter          = r_iter + 1'b1;
                if (r_iter == LAST_ITER) begin
                    n_state = S_DIV_LD;
                end
            end
            S_DIV_LD: begin
                o_cmd.div_load = 1'b1;
                n_iter         = '0;
                n_state        = S_DIVIDE;
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                n_iter         = r_iter + 1'b1;
                if (r_iter == LAST_ITER) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // wait for the output register to drain
                if (!r_out_valid || i_result_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ sv/wsd_datapath.sv @@
// Accumulators, multipliers, iterative square root and dividers for window_std_deviation.
module wsd_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wsd_pkg::WIN_W-1:0]     i_cfg_wdata,
    input  logic [wsd_pkg::SAMPLE_W-1:0]  i_sample,
    input  wsd_pkg::t_cmd                 i_cmd,
    output wsd_pkg::t_status              o_status,
    output logic [wsd_pkg::STD_W-1:0]     o_std_dev,
    output logic [wsd_pkg::MEAN_W-1:0]    o_mean_value
);

    localparam int WIN_W   = wsd_pkg::WIN_W;
    localparam int SUM_W   = wsd_pkg::SUM_W;
    localparam int SQ_W    = wsd_pkg::SQ_W;
    localparam int SPLIT_W = wsd_pkg::SPLIT_W;
    localparam int PART_W  = wsd_pkg::PART_W;
    localparam int NSQ_W   = wsd_pkg::NSQ_W;
    localparam int PSQ_W   = wsd_pkg::PSQ_W;
    localparam int RAD_W   = wsd_pkg::RAD_W;
    localparam int ROOT_W  = wsd_pkg::ROOT_W;
    localparam int REM_W   = wsd_pkg::REM_W;

    logic [WIN_W-1:0]  r_window_length;
    logic [WIN_W-1:0]  r_count;
    logic [SUM_W-1:0]  r_sum;
    logic [SQ_W-1:0]   r_sqsum;

    logic [WIN_W-1:0]  n_eff;
    logic [WIN_W-1:0]  n_count;
    logic [SUM_W-1:0]  n_sum;
    logic [SQ_W-1:0]   n_sqsum;
    logic [2*wsd_pkg::SAMPLE_W-1:0] sample_sq;

    logic [SUM_W-1:0]  r_s1;
    logic [SQ_W-1:0]   r_s2;
    logic [WIN_W-1:0]  r_n;
    logic [PSQ_W-1:0]  r_psq;
    logic [PART_W-1:0] r_plo;
    logic [PART_W-1:0] r_phi;
    logic [NSQ_W-1:0]  r_nsq;
    logic [NSQ_W-1:0]  var_w;

    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  r_rem;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    logic [ROOT_W-1:0] r_qa, r_qb;
    logic [WIN_W-1:0]  r_ra, r_rb;
    logic [WIN_W:0]    ra_sh, rb_sh;

    logic [wsd_pkg::STD_W-1:0]  r_std_dev;
    logic [wsd_pkg::MEAN_W-1:0] r_mean_value;

    // effective window: zero acts as one, large values clamp
    always_comb begin
        if (r_window_length == '0) begin
            n_eff = WIN_W'(1);
        end else if (r_window_length > WIN_W'(wsd_pkg::MAX_WINDOW)) begin
            n_eff = WIN_W'(wsd_pkg::MAX_WINDOW);
        end else begin
            n_eff = r_window_length;
        end
    end

    assign sample_sq      = i_sample * i_sample;
    assign n_count        = r_count + 1'b1;
    assign n_sum          = r_sum + SUM_W'(i_sample);
    assign n_sqsum        = r_sqsum + SQ_W'(sample_sq);
    assign o_status.close = (n_count >= n_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WIN_W'(wsd_pkg::WIN_RESET);
            r_count         <= '0;
            r_sum           <= '0;
            r_sqsum         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window_length <= i_cfg_wdata;
            end
            if (i_cmd.acc) begin
                if (o_status.close) begin
                    r_count <= '0;
                    r_sum   <= '0;
                    r_sqsum <= '0;
                end else begin
                    r_count <= n_count;
                    r_sum   <= n_sum;
                    r_sqsum <= n_sqsum;
                end
            end
        end
    end

    // variance numerator N*S2 - S1^2, clamped at zero
    assign var_w = (r_nsq >= NSQ_W'(r_psq)) ? (r_nsq - NSQ_W'(r_psq)) : '0;

    // one root digit: bring down two radicand bits, try (2*root)*2+1
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = REM_W'({r_root, 2'b01});

    // one quotient bit per lane
    assign ra_sh = {r_ra, r_qa[ROOT_W-1]};
    assign rb_sh = {r_rb, r_qb[ROOT_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && o_status.close) begin
            r_s1 <= n_sum;
            r_s2 <= n_sqsum;
            r_n  <= n_eff;
        end
        if (i_cmd.mul_sq) begin
            r_psq <= PSQ_W'(r_s1) * PSQ_W'(r_s1);
            r_plo <= PART_W'(r_n) * PART_W'(r_s2[SPLIT_W-1:0]);
        end
        if (i_cmd.mul_hi) begin
            r_phi <= PART_W'(r_n) * PART_W'(r_s2[SQ_W-1:SPLIT_W]);
        end
        if (i_cmd.sum) begin
            r_nsq <= (NSQ_W'(r_phi) << SPLIT_W) + NSQ_W'(r_plo);
        end
        if (i_cmd.sub) begin
            r_rad  <= RAD_W'(var_w) << 8;
            r_root <= '0;
            r_rem  <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_rad <= r_rad << 2;
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.div_load) begin
            r_qa <= r_root;
            r_qb <= ROOT_W'({r_s1, 4'b0000});
            r_ra <= '0;
            r_rb <= '0;
        end
        if (i_cmd.div_step) begin
            if (ra_sh >= {1'b0, r_n}) begin
                r_ra <= WIN_W'(ra_sh - {1'b0, r_n});
                r_qa <= {r_qa[ROOT_W-2:0], 1'b1};
            end else begin
                r_ra <= WIN_W'(ra_sh);
                r_qa <= {r_qa[ROOT_W-2:0], 1'b0};
            end
            if (rb_sh >= {1'b0, r_n}) begin
                r_rb <= WIN_W'(rb_sh - {1'b0, r_n});
                r_qb <= {r_qb[ROOT_W-2:0], 1'b1};
            end else begin
                r_rb <= WIN_W'(rb_sh);
                r_qb <= {r_qb[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            r_std_dev    <= r_qa[wsd_pkg::STD_W-1:0];
            r_mean_value <= r_qb[wsd_pkg::MEAN_W-1:0];
        end
    end

    assign o_std_dev    = r_std_dev;
    assign o_mean_value = r_mean_value;

endmodule

@@ sv/window_std_deviation.sv @@
// Top level of window_std_deviation: windowed mean and standard deviation of samples.
//
// Input channel (i_sample_valid / o_sample_ready): one 12-bit converter sample
// per transaction. Each sample is added to a count, a sum and a sum of squares
// in the cycle it is accepted.
// Output channel (o_result_valid / i_result_ready): when the count reaches the
// window length N (zero acts as 1, values above 4096 clamp to 4096), one
// transaction carries o_mean_value = floor(16*S1/N), unsigned 12.4, and
// o_std_dev = floor(isqrt(256*(N*S2 - S1^2))/N), unsigned 11.4.
// Throughput: samples that do not close a window take one cycle each. The
// closing sample starts a sequence: low-half and high-half multiply states, a
// combine and a subtract state, a 29-step square root, a divider load, 29
// steps of a two-lane restoring divider (deviation and mean) and a hand-off
// state that waits for the output register to drain. The sample port is held
// off meanwhile; the next sample is taken after the hand-off state.
// Results sit in an output register; while the receiver stalls, sampling goes
// on, and only a following window end waits for that register to drain.
// Reset (i_rst_n low, synchronous): accumulators cleared, window length 100,
// no result pending. Writes via i_cfg_we do not clear the accumulators; a
// shorter window closes on the next sample if the count already reaches it.
module window_std_deviation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wsd_pkg::WIN_W-1:0]     i_cfg_wdata,
    input  logic                          i_sample_valid,
    output logic                          o_sample_ready,
    input  logic [wsd_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                          o_result_valid,
    input  logic                          i_result_ready,
    output logic [wsd_pkg::STD_W-1:0]     o_std_dev,
    output logic [wsd_pkg::MEAN_W-1:0]    o_mean_value
);

    wsd_pkg::t_cmd    cmd;
    wsd_pkg::t_status status;

    // sequencer: owns the handshakes and steps the datapath
    wsd_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .i_status       (status),
        .o_cmd          (cmd)
    );

    // accumulators, window register and arithmetic units
    wsd_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_sample     (i_sample),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_std_dev    (o_std_dev),
        .o_mean_value (o_mean_value)
    );

endmodule
